/* hw/rtl/scene_text_tokenizer_top_macros.svh */
// ----------------------------------------------------------------------------
// scene text tokenizer assertion macros
// concurrent checks sampled on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SCENE_TEXT_TOKENIZER_TOP_MACROS_SVH
`define SCENE_TEXT_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// request and result types and character codes of the scene text tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} chr_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic [2:0] token_kind;
		logic       token_first;
		logic       token_last;
		logic       prev_closed;
		logic [1:0] error_code;
	} tok_t;

	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_WORD    = 3'd1;
	localparam logic [2:0] KIND_STRING  = 3'd2;
	localparam logic [2:0] KIND_BRACKET = 3'd3;
	localparam logic [2:0] KIND_COMMENT = 3'd4;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_EOF    = 2'd1;
	localparam logic [1:0] ERR_NL     = 2'd2;
	localparam logic [1:0] ERR_ESCAPE = 2'd3;

	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_FF     = 8'h0c;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6e;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

endpackage

/* hw/rtl/scene_text_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// scene_text_tokenizer_top
// tags each byte of a text stream with its token role, decoding string escapes
// ----------------------------------------------------------------------------
// channel  dir  payload  handshake
// chr      in   chr_t    chr_valid / chr_stall
// tok      out  tok_t    tok_valid / tok_stall
//
// one request accepted per cycle while chr_stall is low, one result per request
// a request lands in the input register at acceptance and moves on to the result
// register when the lexer takes it, which is when its result becomes valid
// the lexer mode register updates as a request moves into the result register
// reset empties both stages and sets the lexer idle between tokens
// tok_stall backs up through both stages to chr_stall once both are full
// ----------------------------------------------------------------------------
module scene_text_tokenizer_top import stt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic chr_valid,
	output logic chr_stall,
	input  chr_t chr,
	output logic tok_valid,
	input  logic tok_stall,
	output tok_t tok
);

	logic req_valid;
	logic req_stall;
	chr_t req;

	stt_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req)
	);

	stt_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok)
	);

endmodule

/* hw/rtl/stt_in_stage.sv */
// ----------------------------------------------------------------------------
// stt_in_stage
// input register: captures one request per cycle, holds it while downstream stalls
// ----------------------------------------------------------------------------
module stt_in_stage import stt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic chr_valid,
	output logic chr_stall,
	input  chr_t chr,
	output logic req_valid,
	input  logic req_stall,
	output chr_t req
);

	logic req_valid_s1;
	chr_t req_s1;

	assign chr_stall = req_valid_s1 & req_stall;
	assign req_valid = req_valid_s1;
	assign req       = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!chr_stall) begin
			req_valid_s1 <= chr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr_valid && !chr_stall) begin
			req_s1 <= chr;
		end
	end

endmodule

/* hw/rtl/stt_lexer.sv */
// ----------------------------------------------------------------------------
// stt_lexer
// lexer mode register, per-byte token classification and result register
// ----------------------------------------------------------------------------
`include "scene_text_tokenizer_top_macros.svh"

module stt_lexer import stt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  chr_t req,
	output logic tok_valid,
	input  logic tok_stall,
	output tok_t tok
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_WORD,
		M_COMMENT,
		M_STRING,
		M_ESCAPE,
		M_ERR_EOF,
		M_ERR_NL,
		M_ERR_ESC
	} mode_t;

	mode_t mode_q;
	mode_t mode_d;
	mode_t start_mode;
	tok_t  res_d;
	tok_t  start_res;
	tok_t  res_s2;
	logic  res_valid_s2;
	logic  take;
	logic  [7:0] c;
	logic  eoi;
	logic  blank;
	logic  is_bracket;
	logic  esc_ok;
	logic  [7:0] esc_byte;

	assign c    = req.in_byte;
	assign eoi  = req.end_of_input;
	assign take = req_valid & ~req_stall;

	assign req_stall = res_valid_s2 & tok_stall;
	assign tok_valid = res_valid_s2;
	assign tok       = res_s2;

	assign blank      = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	assign is_bracket = (c == CH_LBRACK) || (c == CH_RBRACK);

	always_comb begin
		esc_ok   = 1'b1;
		esc_byte = c;
		case (c)
			CH_LOW_B: esc_byte = CH_BS;
			CH_LOW_F: esc_byte = CH_FF;
			CH_LOW_N: esc_byte = CH_LF;
			CH_LOW_R: esc_byte = CH_CR;
			CH_LOW_T: esc_byte = CH_TAB;
			CH_BSLASH, CH_SQUOTE, CH_DQUOTE: esc_byte = c;
			default: esc_ok = 1'b0;
		endcase
	end

	// token start as seen between tokens
	always_comb begin
		start_res  = '0;
		start_mode = M_IDLE;
		if (!blank) begin
			start_res.out_byte    = c;
			start_res.out_valid   = 1'b1;
			start_res.token_first = 1'b1;
			if (c == CH_DQUOTE) begin
				start_res.token_kind = KIND_STRING;
				start_mode           = M_STRING;
			end else if (is_bracket) begin
				start_res.token_kind = KIND_BRACKET;
				start_res.token_last = 1'b1;
			end else if (c == CH_HASH) begin
				start_res.token_kind = KIND_COMMENT;
				start_mode           = M_COMMENT;
			end else begin
				start_res.token_kind = KIND_WORD;
				start_mode           = M_WORD;
			end
		end
	end

	always_comb begin
		res_d  = '0;
		mode_d = mode_q;
		case (mode_q)
			M_IDLE: begin
				if (!eoi) begin
					res_d  = start_res;
					mode_d = start_mode;
				end
			end
			M_WORD: begin
				if (eoi) begin
					res_d.prev_closed = 1'b1;
					mode_d            = M_IDLE;
				end else if (blank || c == CH_DQUOTE || is_bracket) begin
					res_d             = start_res;
					res_d.prev_closed = 1'b1;
					mode_d            = start_mode;
				end else begin
					res_d.out_byte   = c;
					res_d.out_valid  = 1'b1;
					res_d.token_kind = KIND_WORD;
				end
			end
			M_COMMENT: begin
				if (eoi || c == CH_LF || c == CH_CR) begin
					res_d.prev_closed = 1'b1;
					mode_d            = M_IDLE;
				end else begin
					res_d.out_byte   = c;
					res_d.out_valid  = 1'b1;
					res_d.token_kind = KIND_COMMENT;
				end
			end
			M_STRING: begin
				if (eoi) begin
					res_d.error_code = ERR_EOF;
					mode_d           = M_ERR_EOF;
				end else if (c == CH_DQUOTE) begin
					res_d.out_byte   = c;
					res_d.out_valid  = 1'b1;
					res_d.token_kind = KIND_STRING;
					res_d.token_last = 1'b1;
					mode_d           = M_IDLE;
				end else if (c == CH_LF) begin
					res_d.error_code = ERR_NL;
					mode_d           = M_ERR_NL;
				end else if (c == CH_BSLASH) begin
					// backslash itself yields no text
					mode_d = M_ESCAPE;
				end else begin
					res_d.out_byte   = c;
					res_d.out_valid  = 1'b1;
					res_d.token_kind = KIND_STRING;
				end
			end
			M_ESCAPE: begin
				if (eoi) begin
					res_d.error_code = ERR_EOF;
					mode_d           = M_ERR_EOF;
				end else if (!esc_ok) begin
					res_d.error_code = ERR_ESCAPE;
					mode_d           = M_ERR_ESC;
				end else begin
					res_d.out_byte   = esc_byte;
					res_d.out_valid  = 1'b1;
					res_d.token_kind = KIND_STRING;
					mode_d           = M_STRING;
				end
			end
			M_ERR_EOF: res_d.error_code = ERR_EOF;
			M_ERR_NL:  res_d.error_code = ERR_NL;
			M_ERR_ESC: res_d.error_code = ERR_ESCAPE;
			default:   res_d.error_code = ERR_ESCAPE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			res_valid_s2 <= 1'b0;
			res_s2       <= '0;
		end else begin
			if (take) begin
				mode_q       <= mode_d;
				res_s2       <= res_d;
				res_valid_s2 <= 1'b1;
			end else if (!tok_stall) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	`STT_ASSERT_NEXT(a_err_sticky,
		mode_q == M_ERR_EOF || mode_q == M_ERR_NL || mode_q == M_ERR_ESC,
		$stable(mode_q), "error mode left before reset")
	`STT_ASSERT_NOW(a_empty_clean, tok_valid && !tok.out_valid,
		tok.out_byte == 8'd0 && tok.token_kind == KIND_NONE && !tok.token_first
		&& !tok.token_last, "text fields set without text byte")
	`STT_ASSERT_NOW(a_err_no_text, tok_valid && tok.error_code != ERR_NONE,
		!tok.out_valid && !tok.prev_closed, "text reported alongside an error")
	`STT_ASSERT_NOW(a_last_kind, tok_valid && tok.token_last,
		tok.token_kind == KIND_STRING || tok.token_kind == KIND_BRACKET,
		"token end on a word or comment byte")
	`STT_ASSERT_NEXT(a_hold_result, tok_valid && tok_stall,
		tok_valid && $stable(tok) && $stable(mode_q), "stalled result or mode changed")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the scene text tokenizer: directed rows, then random
// token streams with request gaps and result stalls, checked by a byte tagger
// ----------------------------------------------------------------------------
module tb;
	import stt_pkg::*;

	typedef enum logic [2:0] {
		LX_IDLE, LX_WORD, LX_COMMENT, LX_STRING, LX_ESCAPE, LX_ERR_EOF, LX_ERR_NL, LX_ERR_ESC
	} lex_mode_t;

	typedef enum int {
		TAIL_EOF_STRING, TAIL_EOF_ESCAPE, TAIL_NL_STRING, TAIL_BAD_ESCAPE, TAIL_ESCAPED_NL
	} tail_t;

	typedef struct packed {
		chr_t req;
		logic typed;
		tok_t want;
	} row_t;

	localparam tok_t QUIET = '0;
	localparam int N_RANDOM = 700;
	localparam int N_DIR = 31;
	localparam int ODDS [4] = '{0, 10, 30, 60};
	localparam logic [7:0] ESC_CHARS [8] = '{CH_LOW_B, CH_LOW_F, CH_LOW_N, CH_LOW_R,
		CH_LOW_T, CH_BSLASH, CH_SQUOTE, CH_DQUOTE};
	localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

	// expected result is typed only where it is obvious, else the tagger decides
	localparam row_t DIRECTED [N_DIR] = '{
		'{'{8'hff, 1'b1}, 1'b1, QUIET},
		'{'{8'h00, 1'b0}, 1'b1, tok_t'{8'h00, 1'b1, KIND_WORD, 1'b1, 1'b0, 1'b0, ERR_NONE}},
		'{'{8'hff, 1'b0}, 1'b1, tok_t'{8'hff, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0, ERR_NONE}},
		'{'{CH_HASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_LBRACK, 1'b0}, 1'b1,
			tok_t'{CH_LBRACK, 1'b1, KIND_BRACKET, 1'b1, 1'b1, 1'b1, ERR_NONE}},
		'{'{CH_RBRACK, 1'b0}, 1'b1,
			tok_t'{CH_RBRACK, 1'b1, KIND_BRACKET, 1'b1, 1'b1, 1'b0, ERR_NONE}},
		'{'{CH_HASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_CR, 1'b0}, 1'b0, QUIET},
		'{'{CH_HASH, 1'b0}, 1'b0, QUIET},
		'{'{8'h00, 1'b1}, 1'b0, QUIET},
		'{'{8'h41, 1'b0}, 1'b0, QUIET},
		'{'{8'hff, 1'b1}, 1'b0, QUIET},
		'{'{CH_DQUOTE, 1'b0}, 1'b0, QUIET},
		'{'{CH_CR, 1'b0}, 1'b0, QUIET},
		'{'{CH_BSLASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_LOW_B, 1'b0}, 1'b0, QUIET},
		'{'{CH_BSLASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_LOW_F, 1'b0}, 1'b0, QUIET},
		'{'{CH_BSLASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_LOW_N, 1'b0}, 1'b0, QUIET},
		'{'{CH_BSLASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_LOW_R, 1'b0}, 1'b0, QUIET},
		'{'{CH_BSLASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_LOW_T, 1'b0}, 1'b0, QUIET},
		'{'{CH_BSLASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_BSLASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_BSLASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_SQUOTE, 1'b0}, 1'b0, QUIET},
		'{'{CH_BSLASH, 1'b0}, 1'b0, QUIET},
		'{'{CH_DQUOTE, 1'b0}, 1'b0, QUIET},
		'{'{CH_DQUOTE, 1'b0}, 1'b0, QUIET}
	};

	logic clk;
	logic arst_n;
	logic chr_valid;
	logic chr_stall;
	chr_t chr;
	logic tok_valid;
	logic tok_stall;
	tok_t tok;

	lex_mode_t lex_mode = LX_IDLE;
	tok_t tags_due [$];
	int mismatches = 0;
	int sent = 0;
	int gap_odds = 0;
	int stall_odds = 0;
	bit clean = 1'b1;

	scene_text_tokenizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.chr_valid(chr_valid),
		.chr_stall(chr_stall),
		.chr(chr),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok(tok)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	function automatic logic is_escape(input logic [7:0] b);
		foreach (ESC_CHARS[i])
			if (ESC_CHARS[i] == b)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic tok_t mark(input logic [7:0] b, input logic [2:0] kind,
			input logic is_first, input logic is_last);
		tok_t t;
		t = '0;
		t.out_byte = b;
		t.out_valid = 1'b1;
		t.token_kind = kind;
		t.token_first = is_first;
		t.token_last = is_last;
		return t;
	endfunction

	// byte seen between tokens: whitespace is dropped, anything else opens a token
	function automatic tok_t open_token(input logic [7:0] b);
		tok_t t;
		t = '0;
		if (is_blank(b)) begin
			lex_mode = LX_IDLE;
		end else if (b == CH_DQUOTE) begin
			t = mark(b, KIND_STRING, 1'b1, 1'b0);
			lex_mode = LX_STRING;
		end else if (b == CH_LBRACK || b == CH_RBRACK) begin
			t = mark(b, KIND_BRACKET, 1'b1, 1'b1);
			lex_mode = LX_IDLE;
		end else if (b == CH_HASH) begin
			t = mark(b, KIND_COMMENT, 1'b1, 1'b0);
			lex_mode = LX_COMMENT;
		end else begin
			t = mark(b, KIND_WORD, 1'b1, 1'b0);
			lex_mode = LX_WORD;
		end
		return t;
	endfunction

	function automatic tok_t tag_byte(input chr_t c);
		tok_t t;
		logic [7:0] b;
		logic eoi;
		t = '0;
		b = c.in_byte;
		eoi = c.end_of_input;
		case (lex_mode)
			LX_IDLE: begin
				if (!eoi)
					t = open_token(b);
			end
			LX_WORD: begin
				if (eoi) begin
					t.prev_closed = 1'b1;
					lex_mode = LX_IDLE;
				end else if (is_blank(b) || b == CH_DQUOTE || b == CH_LBRACK || b == CH_RBRACK) begin
					t = open_token(b);
					t.prev_closed = 1'b1;
				end else begin
					t = mark(b, KIND_WORD, 1'b0, 1'b0);
				end
			end
			LX_COMMENT: begin
				if (eoi || b == CH_LF || b == CH_CR) begin
					t.prev_closed = 1'b1;
					lex_mode = LX_IDLE;
				end else begin
					t = mark(b, KIND_COMMENT, 1'b0, 1'b0);
				end
			end
			LX_STRING: begin
				if (eoi) begin
					t.error_code = ERR_EOF;
					lex_mode = LX_ERR_EOF;
				end else if (b == CH_DQUOTE) begin
					t = mark(b, KIND_STRING, 1'b0, 1'b1);
					lex_mode = LX_IDLE;
				end else if (b == CH_LF) begin
					t.error_code = ERR_NL;
					lex_mode = LX_ERR_NL;
				end else if (b == CH_BSLASH) begin
					lex_mode = LX_ESCAPE;
				end else begin
					t = mark(b, KIND_STRING, 1'b0, 1'b0);
				end
			end
			LX_ESCAPE: begin
				if (eoi) begin
					t.error_code = ERR_EOF;
					lex_mode = LX_ERR_EOF;
				end else begin
					lex_mode = LX_STRING;
					case (b)
						CH_LOW_B: t = mark(CH_BS, KIND_STRING, 1'b0, 1'b0);
						CH_LOW_F: t = mark(CH_FF, KIND_STRING, 1'b0, 1'b0);
						CH_LOW_N: t = mark(CH_LF, KIND_STRING, 1'b0, 1'b0);
						CH_LOW_R: t = mark(CH_CR, KIND_STRING, 1'b0, 1'b0);
						CH_LOW_T: t = mark(CH_TAB, KIND_STRING, 1'b0, 1'b0);
						CH_BSLASH, CH_SQUOTE, CH_DQUOTE: t = mark(b, KIND_STRING, 1'b0, 1'b0);
						default: begin
							t.error_code = ERR_ESCAPE;
							lex_mode = LX_ERR_ESC;
						end
					endcase
				end
			end
			LX_ERR_EOF: t.error_code = ERR_EOF;
			LX_ERR_NL: t.error_code = ERR_NL;
			default: t.error_code = ERR_ESCAPE;
		endcase
		return t;
	endfunction

	// until the closing phase, keep open strings away from the sticky errors
	function automatic chr_t keep_string_legal(input chr_t c);
		chr_t s;
		s = c;
		if (lex_mode == LX_STRING) begin
			s.end_of_input = 1'b0;
			if (s.in_byte == CH_LF)
				s.in_byte = CH_CR;
		end else if (lex_mode == LX_ESCAPE) begin
			s.end_of_input = 1'b0;
			if (!is_escape(s.in_byte))
				s.in_byte = ESC_CHARS[$urandom_range(0, 7)];
		end
		return s;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do
			b = rand_byte();
		while (is_blank(b) || b == CH_DQUOTE || b == CH_LBRACK || b == CH_RBRACK);
		return b;
	endfunction

	function automatic logic [7:0] string_byte();
		logic [7:0] b;
		do
			b = rand_byte();
		while (b == CH_DQUOTE || b == CH_BSLASH || b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] comment_byte();
		logic [7:0] b;
		do
			b = rand_byte();
		while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	// appends one expected result to the scoreboard queue
	function automatic void note_tag(input tok_t t);
		tags_due = {tags_due, t};
	endfunction

	task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
		$display("tok %s: got 0x%02h, want 0x%02h at %0t", field, got, want, $time);
		mismatches++;
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(input chr_t c, input logic typed, input tok_t want);
		chr_t r;
		tok_t guess;
		r = c;
		if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
			chr_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		if (clean && !typed)
			r = keep_string_legal(r);
		chr_valid <= 1'b1;
		chr <= r;
		do
			@(posedge clk);
		while (chr_stall);
		guess = tag_byte(r);
		note_tag(typed ? want : guess);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eoi);
		chr_t c;
		c.in_byte = b;
		c.end_of_input = eoi;
		send_req(c, 1'b0, QUIET);
	endtask

	task automatic drain_results();
		chr_valid <= 1'b0;
		while (tags_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		tok_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (tags_due.size() == 0) begin
				report("unexpected result, byte", tok.out_byte, 8'h00);
			end else begin
				want = tags_due.pop_front();
				if (tok.out_byte !== want.out_byte)
					report("out_byte", tok.out_byte, want.out_byte);
				if (tok.out_valid !== want.out_valid)
					report("out_valid", 8'(tok.out_valid), 8'(want.out_valid));
				if (tok.token_kind !== want.token_kind)
					report("token_kind", 8'(tok.token_kind), 8'(want.token_kind));
				if (tok.token_first !== want.token_first)
					report("token_first", 8'(tok.token_first), 8'(want.token_first));
				if (tok.token_last !== want.token_last)
					report("token_last", 8'(tok.token_last), 8'(want.token_last));
				if (tok.prev_closed !== want.prev_closed)
					report("prev_closed", 8'(tok.prev_closed), 8'(want.prev_closed));
				if (tok.error_code !== want.error_code)
					report("error_code", 8'(tok.error_code), 8'(want.error_code));
			end
		end
	end

	// result stalls in bursts of random length
	initial begin
		int burst;
		burst = 0;
		tok_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (burst > 0)
				burst--;
			else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds)
				burst = $urandom_range(1, 9);
			tok_stall <= (burst > 0);
		end
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int len;
		int pick;
		int next_shuffle;
		bit mid_drained;
		tail_t tail;
		logic [7:0] b;
		arst_n = 1'b0;
		chr_valid = 1'b0;
		chr = '0;
		mid_drained = 1'b0;
		next_shuffle = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		gap_odds = ODDS[$urandom_range(0, 3)];
		stall_odds = ODDS[$urandom_range(0, 3)];
		foreach (DIRECTED[i])
			send_req(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
		drain_results();

		next_shuffle = sent;
		while (sent < N_DIR + N_RANDOM) begin
			if (sent >= N_DIR + N_RANDOM - 100) begin
				gap_odds = 0;
				stall_odds = 0;
			end else if (sent >= next_shuffle) begin
				gap_odds = ODDS[$urandom_range(0, 3)];
				stall_odds = ODDS[$urandom_range(0, 3)];
				next_shuffle += 60;
			end
			if (!mid_drained && sent >= N_DIR + N_RANDOM / 2) begin
				drain_results();
				mid_drained = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				len = $urandom_range(1, 8);
				repeat (len) send_byte(word_byte(), 1'b0);
			end else if (pick < 42) begin
				send_byte(CH_DQUOTE, 1'b0);
				len = $urandom_range(0, 8);
				repeat (len) begin
					if ($urandom_range(0, 4) == 0) begin
						send_byte(CH_BSLASH, 1'b0);
						send_byte(ESC_CHARS[$urandom_range(0, 7)], 1'b0);
					end else begin
						send_byte(string_byte(), 1'b0);
					end
				end
				// now and then leave the string open
				if ($urandom_range(0, 9) != 0)
					send_byte(CH_DQUOTE, 1'b0);
			end else if (pick < 52) begin
				send_byte(CH_HASH, 1'b0);
				len = $urandom_range(0, 8);
				repeat (len) send_byte(comment_byte(), 1'b0);
				if ($urandom_range(0, 2) != 0)
					send_byte($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
			end else if (pick < 62) begin
				send_byte($urandom_range(0, 1) ? CH_LBRACK : CH_RBRACK, 1'b0);
			end else if (pick < 80) begin
				len = $urandom_range(1, 3);
				repeat (len) send_byte(BLANKS[$urandom_range(0, 3)], 1'b0);
			end else if (pick < 85) begin
				send_byte(rand_byte(), 1'b1);
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) send_byte(rand_byte(), $urandom_range(0, 7) == 0);
			end
		end

		// back to idle, then into one sticky error and twelve requests after it
		if (lex_mode == LX_ESCAPE)
			send_byte(CH_LOW_N, 1'b0);
		if (lex_mode == LX_STRING)
			send_byte(CH_DQUOTE, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_DQUOTE, 1'b0);
		send_byte(string_byte(), 1'b0);
		tail = tail_t'($urandom_range(0, 4));
		if (tail == TAIL_EOF_ESCAPE || tail == TAIL_BAD_ESCAPE || tail == TAIL_ESCAPED_NL)
			send_byte(CH_BSLASH, 1'b0);
		clean = 1'b0;
		case (tail)
			TAIL_EOF_STRING, TAIL_EOF_ESCAPE: send_byte(rand_byte(), 1'b1);
			TAIL_BAD_ESCAPE: begin
				do
					b = rand_byte();
				while (is_escape(b));
				send_byte(b, 1'b0);
			end
			default: send_byte(CH_LF, 1'b0);
		endcase
		repeat (12) send_byte(rand_byte(), $urandom_range(0, 3) == 0);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
